@@ hw/rtl/single_bin_poynting_flux_assert.svh @@
// ---------------------------------------------------------------------------
// Single-bin Poynting flux assertion macros
// Clocked property checks on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SINGLE_BIN_POYNTING_FLUX_ASSERT_SVH
`define SINGLE_BIN_POYNTING_FLUX_ASSERT_SVH
`ifndef SYNTHESIS
// A condition that must hold at every clock edge out of reset.
`define SBPF_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// A condition that, once seen, demands a consequence on the next edge.
`define SBPF_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SBPF_ASSERT_ALWAYS(name, cond, msg)
`define SBPF_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

@@ hw/rtl/sbpf_pkg.sv @@
// ---------------------------------------------------------------------------
// Single-bin Poynting flux package
// Shared constants, the front-to-back request types and the sine table
// builder.
// ---------------------------------------------------------------------------
package sbpf_pkg;

    // Default sizes of the block.
    localparam int DEF_TABLE_ADDR_BITS = 8;
    localparam int DEF_SAMPLE_BITS     = 16;
    localparam int DEF_ACC_BITS        = 48;

    // Fixed formats.
    localparam int PHASE_BITS      = 32;
    localparam int Q15_BITS        = 16;
    localparam int FRAC_BITS       = 15;
    localparam int RED_BITS        = 32;
    localparam int FLUX_BITS       = 64;
    localparam int QUEUE_ADDR_BITS = 2;

    localparam logic [Q15_BITS-1:0] FULL_SCALE = 16'd32767;
    localparam longint unsigned HALF_PI_Q30    = 64'd1686629713;

    // Sine and cosine of one request, plus its end-of-record mark.
    typedef struct packed {
        logic signed [Q15_BITS-1:0] sin_q15;
        logic signed [Q15_BITS-1:0] cos_q15;
        logic                       last;
    } trig_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

    // One quarter-wave sine entry in Q15, from a Q30 Taylor series through
    // the thirteenth power, each product truncated back to Q30.
    function automatic logic [Q15_BITS-1:0] sine_entry(input int unsigned k,
                                                       input int unsigned addr_bits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned v;
        x    = (longint'(k) * HALF_PI_Q30) >> addr_bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 64'd6;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd110;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + term;
        v    = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return v[Q15_BITS-1:0];
    endfunction

endpackage

@@ hw/rtl/sbpf_front.sv @@
// ---------------------------------------------------------------------------
// Single-bin Poynting flux front end
// Accepts sample pairs, advances the phase and looks up sine and cosine.
// ---------------------------------------------------------------------------
module sbpf_front import sbpf_pkg::*; #(
    parameter int TABLE_ADDR_BITS = DEF_TABLE_ADDR_BITS,
    parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [PHASE_BITS-1:0]         cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] e_sample,
    input  logic signed [SAMPLE_BITS-1:0] h_sample,
    input  logic                          last,
    input  q_status_t                     q_stat,
    output logic                          q_push,
    output logic signed [SAMPLE_BITS-1:0] q_e,
    output logic signed [SAMPLE_BITS-1:0] q_h,
    output trig_t                         q_trig
);

    localparam int TAB_SIZE = 1 << TABLE_ADDR_BITS;
    localparam int IDX_W    = TABLE_ADDR_BITS + 2;

    logic [PHASE_BITS-1:0]      phase_step_reg;
    logic [PHASE_BITS-1:0]      phase_acc_reg;
    logic [PHASE_BITS-1:0]      phase_acc_next;
    logic [Q15_BITS-1:0]        sine_rom [TAB_SIZE];
    logic [IDX_W-1:0]           lane_p   [2];
    logic [TABLE_ADDR_BITS:0]   lane_j   [2];
    logic [Q15_BITS-1:0]        lane_m   [2];
    logic signed [Q15_BITS-1:0] lane_v   [2];

    // Constant quarter-wave sine table.
    for (genvar k = 0; k < TAB_SIZE; k++)
    begin : g_rom
        assign sine_rom[k] = sine_entry(k, TABLE_ADDR_BITS);
    end

    // Phase step register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            phase_step_reg <= cfg_wr_data;
        end
    end

    // A request is taken whenever the queue has room.
    assign in_stall = q_stat.full;
    assign q_push   = in_valid && !q_stat.full;

    // The phase restarts from zero after the last sample of a record.
    always_comb
    begin
        phase_acc_next = phase_acc_reg;
        if (q_push)
        begin
            phase_acc_next = last ? '0 : phase_acc_reg + phase_step_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg <= '0;
        end
        else
        begin
            phase_acc_reg <= phase_acc_next;
        end
    end

    // Lane 0 gives the sine, lane 1 the cosine as the sine a quarter turn on.
    assign lane_p[0] = phase_acc_reg[PHASE_BITS-1 -: IDX_W];
    assign lane_p[1] = phase_acc_reg[PHASE_BITS-1 -: IDX_W] + IDX_W'(TAB_SIZE);

    // Fold the phase onto the quarter wave and restore the sign.
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            if (lane_p[i][TABLE_ADDR_BITS])
            begin
                lane_j[i] = (TABLE_ADDR_BITS+1)'(TAB_SIZE)
                          - {1'b0, lane_p[i][TABLE_ADDR_BITS-1:0]};
            end
            else
            begin
                lane_j[i] = {1'b0, lane_p[i][TABLE_ADDR_BITS-1:0]};
            end
            lane_m[i] = lane_j[i][TABLE_ADDR_BITS] ? FULL_SCALE
                      : sine_rom[lane_j[i][TABLE_ADDR_BITS-1:0]];
            lane_v[i] = lane_p[i][TABLE_ADDR_BITS+1] ? -$signed(lane_m[i])
                      : $signed(lane_m[i]);
        end
    end

    assign q_e            = e_sample;
    assign q_h            = h_sample;
    assign q_trig.sin_q15 = lane_v[0];
    assign q_trig.cos_q15 = lane_v[1];
    assign q_trig.last    = last;

endmodule

@@ hw/rtl/sbpf_queue.sv @@
// ---------------------------------------------------------------------------
// Single-bin Poynting flux request queue
// Small first-in first-out buffer between the front end and the back end.
// ---------------------------------------------------------------------------
module sbpf_queue import sbpf_pkg::*; #(
    parameter int WIDTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output q_status_t        stat
);

    localparam int DEPTH = 1 << QUEUE_ADDR_BITS;

    logic [WIDTH-1:0]         entry_reg [DEPTH];
    logic [QUEUE_ADDR_BITS:0] wr_ptr_reg;
    logic [QUEUE_ADDR_BITS:0] rd_ptr_reg;

    // Pointers carry one extra bit to tell full from empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg[QUEUE_ADDR_BITS-1:0]] <= push_data;
        end
    end

    assign pop_data       = entry_reg[rd_ptr_reg[QUEUE_ADDR_BITS-1:0]];
    assign stat.not_empty = (wr_ptr_reg != rd_ptr_reg);
    assign stat.full      = (wr_ptr_reg[QUEUE_ADDR_BITS-1:0] == rd_ptr_reg[QUEUE_ADDR_BITS-1:0])
                         && (wr_ptr_reg[QUEUE_ADDR_BITS] != rd_ptr_reg[QUEUE_ADDR_BITS]);

endmodule

@@ hw/rtl/sbpf_back.sv @@
// ---------------------------------------------------------------------------
// Single-bin Poynting flux back end
// Mixes samples down, accumulates the two bins and forms the flux.
// ---------------------------------------------------------------------------
module sbpf_back import sbpf_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int ACC_BITS    = DEF_ACC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  q_status_t                     q_stat,
    input  logic signed [SAMPLE_BITS-1:0] q_e,
    input  logic signed [SAMPLE_BITS-1:0] q_h,
    input  trig_t                         q_trig,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [FLUX_BITS-1:0]   flux
);

    localparam int PROD_W = SAMPLE_BITS + Q15_BITS + 1;
    localparam int SUM_W  = ((ACC_BITS > PROD_W) ? ACC_BITS : PROD_W) + 1;

    localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'({1'b0, {(ACC_BITS-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] SUM_LO = ~SUM_HI;
    localparam logic signed [ACC_BITS-1:0] RED_HI = ACC_BITS'(64'sd2147483647);
    localparam logic signed [ACC_BITS-1:0] RED_LO = ACC_BITS'(-64'sd2147483648);

    logic                        adv;
    logic                        mix_valid_reg;
    logic                        mix_last_reg;
    logic signed [PROD_W-1:0]    mix_er_reg;
    logic signed [PROD_W-1:0]    mix_ei_reg;
    logic signed [PROD_W-1:0]    mix_hr_reg;
    logic signed [PROD_W-1:0]    mix_hi_reg;
    logic signed [ACC_BITS-1:0]  er_acc_reg;
    logic signed [ACC_BITS-1:0]  ei_acc_reg;
    logic signed [ACC_BITS-1:0]  hr_acc_reg;
    logic signed [ACC_BITS-1:0]  hi_acc_reg;
    logic signed [ACC_BITS-1:0]  er_acc_next;
    logic signed [ACC_BITS-1:0]  ei_acc_next;
    logic signed [ACC_BITS-1:0]  hr_acc_next;
    logic signed [ACC_BITS-1:0]  hi_acc_next;
    logic                        cap_valid_reg;
    logic signed [ACC_BITS-1:0]  cap_er_reg;
    logic signed [ACC_BITS-1:0]  cap_ei_reg;
    logic signed [ACC_BITS-1:0]  cap_hr_reg;
    logic signed [ACC_BITS-1:0]  cap_hi_reg;
    logic                        red_valid_reg;
    logic signed [RED_BITS-1:0]  red_er_reg;
    logic signed [RED_BITS-1:0]  red_ei_reg;
    logic signed [RED_BITS-1:0]  red_hr_reg;
    logic signed [RED_BITS-1:0]  red_hi_reg;
    logic                        prod_valid_reg;
    logic signed [FLUX_BITS-1:0] prod_a_reg;
    logic signed [FLUX_BITS-1:0] prod_b_reg;
    logic signed [FLUX_BITS:0]   flux_sum;
    logic                        out_valid_reg;
    logic signed [FLUX_BITS-1:0] flux_reg;

    // Add with saturation at the accumulator range.
    function automatic logic signed [ACC_BITS-1:0] sat_add(
        input logic signed [ACC_BITS-1:0] acc,
        input logic signed [PROD_W-1:0]   d
    );
        logic signed [SUM_W-1:0] sum;
        sum = SUM_W'(acc) + SUM_W'(d);
        if (sum > SUM_HI)
        begin
            return SUM_HI[ACC_BITS-1:0];
        end
        else if (sum < SUM_LO)
        begin
            return SUM_LO[ACC_BITS-1:0];
        end
        return sum[ACC_BITS-1:0];
    endfunction

    // Drop the Q15 fraction (floor) and saturate to 32 bits.
    function automatic logic signed [RED_BITS-1:0] reduce32(
        input logic signed [ACC_BITS-1:0] acc
    );
        logic signed [ACC_BITS-1:0] sh;
        sh = acc >>> FRAC_BITS;
        if (sh > RED_HI)
        begin
            return RED_HI[RED_BITS-1:0];
        end
        else if (sh < RED_LO)
        begin
            return RED_LO[RED_BITS-1:0];
        end
        return sh[RED_BITS-1:0];
    endfunction

    // The whole pipe moves unless a finished result is held at the output.
    assign adv   = !out_valid_reg || !out_stall;
    assign q_pop = adv && q_stat.not_empty;

    // Mixing stage: sample times cosine and minus sample times sine.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            mix_valid_reg <= q_stat.not_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            mix_last_reg <= q_trig.last;
            mix_er_reg   <= PROD_W'(q_e) * PROD_W'(q_trig.cos_q15);
            mix_ei_reg   <= -(PROD_W'(q_e) * PROD_W'(q_trig.sin_q15));
            mix_hr_reg   <= PROD_W'(q_h) * PROD_W'(q_trig.cos_q15);
            mix_hi_reg   <= -(PROD_W'(q_h) * PROD_W'(q_trig.sin_q15));
        end
    end

    // Accumulation stage.
    always_comb
    begin
        er_acc_next = sat_add(er_acc_reg, mix_er_reg);
        ei_acc_next = sat_add(ei_acc_reg, mix_ei_reg);
        hr_acc_next = sat_add(hr_acc_reg, mix_hr_reg);
        hi_acc_next = sat_add(hi_acc_reg, mix_hi_reg);
    end

    // The last sample of a record moves the sums out and clears the bins.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            er_acc_reg    <= '0;
            ei_acc_reg    <= '0;
            hr_acc_reg    <= '0;
            hi_acc_reg    <= '0;
            cap_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            cap_valid_reg <= mix_valid_reg && mix_last_reg;
            if (mix_valid_reg)
            begin
                if (mix_last_reg)
                begin
                    er_acc_reg <= '0;
                    ei_acc_reg <= '0;
                    hr_acc_reg <= '0;
                    hi_acc_reg <= '0;
                end
                else
                begin
                    er_acc_reg <= er_acc_next;
                    ei_acc_reg <= ei_acc_next;
                    hr_acc_reg <= hr_acc_next;
                    hi_acc_reg <= hi_acc_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && mix_valid_reg && mix_last_reg)
        begin
            cap_er_reg <= er_acc_next;
            cap_ei_reg <= ei_acc_next;
            cap_hr_reg <= hr_acc_next;
            cap_hi_reg <= hi_acc_next;
        end
    end

    // Reduction, cross products and output stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            red_valid_reg  <= cap_valid_reg;
            prod_valid_reg <= red_valid_reg;
            out_valid_reg  <= prod_valid_reg;
        end
    end

    assign flux_sum = (FLUX_BITS+1)'(prod_a_reg) + (FLUX_BITS+1)'(prod_b_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (cap_valid_reg)
            begin
                red_er_reg <= reduce32(cap_er_reg);
                red_ei_reg <= reduce32(cap_ei_reg);
                red_hr_reg <= reduce32(cap_hr_reg);
                red_hi_reg <= reduce32(cap_hi_reg);
            end
            if (red_valid_reg)
            begin
                prod_a_reg <= FLUX_BITS'(red_er_reg) * FLUX_BITS'(red_hr_reg);
                prod_b_reg <= FLUX_BITS'(red_ei_reg) * FLUX_BITS'(red_hi_reg);
            end
            if (prod_valid_reg)
            begin
                // Half of the exact sum, rounded toward minus infinity.
                flux_reg <= flux_sum[FLUX_BITS:1];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign flux      = flux_reg;

endmodule

@@ hw/rtl/single_bin_poynting_flux.sv @@
// ---------------------------------------------------------------------------
// Single-bin Poynting flux
// Spectral Poynting flux of one DFT bin of paired E and H field samples.
// ---------------------------------------------------------------------------
// The block takes one E/H sample pair per clock cycle while in_stall is low.
// The front end turns the phase accumulator into sine and cosine from a
// quarter-wave table and hands each request to a four-entry queue; the back
// end mixes, accumulates into saturating bins and, after the sample marked
// last, forms 0.5*Re[E*conj(H)]. The last sample passes through the queue
// and the mix, accumulate, reduce, cross multiply and output registers before
// the flux appears. The single accumulate stage sets the sustained rate at one
// sample per cycle while nothing stalls, and a held result stalls the back
// end and, once the queue is full, the input. phase_step is written through
// cfg_wr_en and cfg_wr_data and takes effect on the next phase advance.
module single_bin_poynting_flux import sbpf_pkg::*; #(
    parameter int TABLE_ADDR_BITS = DEF_TABLE_ADDR_BITS,
    parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS,
    parameter int ACC_BITS        = DEF_ACC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [PHASE_BITS-1:0]         cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] e_sample,
    input  logic signed [SAMPLE_BITS-1:0] h_sample,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [FLUX_BITS-1:0]   flux
);

`include "single_bin_poynting_flux_assert.svh"

    localparam int REQ_W = 2 * SAMPLE_BITS + $bits(trig_t);

    q_status_t                     q_stat;
    logic                          q_push;
    logic                          q_pop;
    logic signed [SAMPLE_BITS-1:0] push_e;
    logic signed [SAMPLE_BITS-1:0] push_h;
    trig_t                         push_trig;
    logic [REQ_W-1:0]              pop_data;
    logic signed [SAMPLE_BITS-1:0] pop_e;
    logic signed [SAMPLE_BITS-1:0] pop_h;
    trig_t                         pop_trig;

    // Front end: phase and table lookup.
    sbpf_front #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .e_sample    (e_sample),
        .h_sample    (h_sample),
        .last        (last),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .q_e         (push_e),
        .q_h         (push_h),
        .q_trig      (push_trig)
    );

    // Request queue.
    sbpf_queue #(
        .WIDTH (REQ_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_e, push_h, push_trig}),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    assign {pop_e, pop_h, pop_trig} = pop_data;

    // Back end: mixing, accumulation and flux.
    sbpf_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_BITS    (ACC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_e       (pop_e),
        .q_h       (pop_h),
        .q_trig    (pop_trig),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .flux      (flux)
    );

    // Queue and pipeline consistency checks.
    `SBPF_ASSERT_ALWAYS(a_pop_needs_data, !q_pop || q_stat.not_empty, "pop from empty queue")
    `SBPF_ASSERT_ALWAYS(a_full_not_empty, !q_stat.full || q_stat.not_empty, "queue full and empty")
    `SBPF_ASSERT_NEXT(a_push_lands, q_push, q_stat.not_empty, "pushed request not in queue")

endmodule

@@ sim/tb_single_bin_poynting_flux.sv @@
// ---------------------------------------------------------------------------
// Single-bin Poynting flux testbench
// Streams E/H sample records through the block and checks every flux
// result against a cycle-free model of the DFT bin, the saturating
// accumulators and the cross product. Both sides idle and stall at random.
// ---------------------------------------------------------------------------
module tb_single_bin_poynting_flux import sbpf_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAB_W    = DEF_TABLE_ADDR_BITS;
    localparam int SAMPLE_W = DEF_SAMPLE_BITS;
    localparam int ACC_W    = DEF_ACC_BITS;
    localparam int TAB_SIZE = 1 << TAB_W;
    localparam int IDX_W    = TAB_W + 2;
    localparam int Q15_ONE  = 32767;

    localparam longint ACC_MAX = (longint'(1) << (ACC_W - 1)) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam longint RED_MAX = (longint'(1) << (RED_BITS - 1)) - 1;
    localparam longint RED_MIN = -RED_MAX - 1;

    localparam int SETTLE_CYCLES = 12;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_wr_en;
    logic [PHASE_BITS-1:0]       cfg_wr_data;
    logic                        in_valid;
    logic                        in_stall;
    logic signed [SAMPLE_W-1:0]  e_sample;
    logic signed [SAMPLE_W-1:0]  h_sample;
    logic                        last;
    logic                        out_valid;
    logic                        out_stall;
    logic signed [FLUX_BITS-1:0] flux;

    // Model state: phase, four bin accumulators and the phase step.
    int                    quarter_sine [0:TAB_SIZE];
    logic [PHASE_BITS-1:0] bin_phase;
    logic [PHASE_BITS-1:0] step_now;
    longint                e_re;
    longint                e_im;
    longint                h_re;
    longint                h_im;

    longint expected_flux [$];
    int     error_count;
    int     in_idle_pct;
    int     out_idle_pct;

    single_bin_poynting_flux #(
        .TABLE_ADDR_BITS(TAB_W),
        .SAMPLE_BITS    (SAMPLE_W),
        .ACC_BITS       (ACC_W)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .e_sample   (e_sample),
        .h_sample   (h_sample),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .flux       (flux)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #8_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Quarter-wave sine in Q15 from a truncated Q30 Taylor series.
    function automatic void build_quarter_sine();
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned v;
        longint unsigned div;
        for (int k = 0; k < TAB_SIZE; k++)
        begin
            x    = (longint'(k) * HALF_PI_Q30) >> TAB_W;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (int n = 1; n <= 6; n++)
            begin
                div  = longint'(2 * n) * longint'(2 * n + 1);
                term = ((term * x2) >> 30) / div;
                if (n % 2 == 1)
                begin
                    sum = (sum >= term) ? sum - term : 0;
                end
                else
                begin
                    sum = sum + term;
                end
            end
            v = (sum * Q15_ONE + (64'd1 << 29)) >> 30;
            quarter_sine[k] = (v > Q15_ONE) ? Q15_ONE : int'(v);
        end
        // The quarter index one past the table reads as full scale.
        quarter_sine[TAB_SIZE] = Q15_ONE;
    endfunction

    // Sine of a quadrant-plus-index phase, Q15.
    function automatic longint trig_at(input logic [IDX_W-1:0] p);
        logic [1:0]       quad;
        int               idx;
        longint           mag;
        quad = p[IDX_W-1 -: 2];
        idx  = int'(p[TAB_W-1:0]);
        mag  = quad[0] ? quarter_sine[TAB_SIZE - idx] : quarter_sine[idx];
        return quad[1] ? -mag : mag;
    endfunction

    function automatic longint acc_add(input longint acc, input longint d);
        longint sum;
        sum = acc + d;
        if (sum > ACC_MAX)
        begin
            return ACC_MAX;
        end
        if (sum < ACC_MIN)
        begin
            return ACC_MIN;
        end
        return sum;
    endfunction

    // Drop the fraction (floor) and clamp to 32 bits.
    function automatic longint reduce_bin(input longint acc);
        longint r;
        r = acc >>> FRAC_BITS;
        if (r > RED_MAX)
        begin
            return RED_MAX;
        end
        if (r < RED_MIN)
        begin
            return RED_MIN;
        end
        return r;
    endfunction

    function automatic void clear_bins();
        bin_phase = '0;
        e_re      = 0;
        e_im      = 0;
        h_re      = 0;
        h_im      = 0;
    endfunction

    // Mix one sample pair into the bins; on the record end form the flux.
    function automatic void absorb_sample(input logic signed [SAMPLE_W-1:0] e,
                                          input logic signed [SAMPLE_W-1:0] h,
                                          input logic l,
                                          output bit done,
                                          output longint flux_out);
        logic [IDX_W-1:0] p;
        logic [IDX_W-1:0] pc;
        longint           s;
        longint           c;
        longint           er;
        longint           ei;
        longint           hr;
        longint           hi;
        longint           a;
        longint           b;
        p    = bin_phase[PHASE_BITS-1 -: IDX_W];
        pc   = p + IDX_W'(TAB_SIZE);
        s    = trig_at(p);
        c    = trig_at(pc);
        e_re = acc_add(e_re, longint'(e) * c);
        e_im = acc_add(e_im, -(longint'(e) * s));
        h_re = acc_add(h_re, longint'(h) * c);
        h_im = acc_add(h_im, -(longint'(h) * s));
        bin_phase = bin_phase + step_now;
        done      = l;
        flux_out  = 0;
        if (l)
        begin
            er = reduce_bin(e_re);
            ei = reduce_bin(e_im);
            hr = reduce_bin(h_re);
            hi = reduce_bin(h_im);
            a  = er * hr;
            b  = ei * hi;
            flux_out = (a >>> 1) + (b >>> 1) + ((a & b) & longint'(1));
            clear_bins();
        end
    endfunction

    task automatic report_mismatch(input string what, input logic signed [FLUX_BITS-1:0] got,
                                   input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Present one request and hold it until the block takes it.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] e,
                               input logic signed [SAMPLE_W-1:0] h,
                               input logic l);
        bit     done;
        longint want;
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        e_sample <= e;
        h_sample <= h;
        last     <= l;
        do
            @(posedge clk);
        while (in_stall);
        absorb_sample(e, h, l, done, want);
        if (done)
        begin
            expected_flux = {expected_flux, want};
        end
    endtask

    // Stop sending, wait for every pending flux, then let the pipe settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_flux.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Only called with the block idle.
    task automatic set_phase_step(input logic [PHASE_BITS-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        step_now   = value;
        @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0: return {1'b0, {(SAMPLE_W-1){1'b1}}};
            1: return {1'b1, {(SAMPLE_W-1){1'b0}}};
            2: return SAMPLE_W'($urandom_range(0, 63)) - SAMPLE_W'(32);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [PHASE_BITS-1:0] pick_step();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return PHASE_BITS'($urandom_range(1, 4095));
            3: return 32'h4000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Receiver stall, redrawn every cycle.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_stall <= ($urandom_range(99) < out_idle_pct);
        end
    end

    // Compare each delivered flux with the oldest pending one.
    always @(posedge clk)
    begin : check_flux
        longint want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_flux.size() == 0)
            begin
                report_mismatch("flux with none pending", flux, 0);
            end
            else
            begin
                want = expected_flux.pop_front();
                if (flux !== want)
                begin
                    report_mismatch("flux", flux, want);
                end
            end
        end
    end

    // One-item records at phase zero with the sample extremes.
    task automatic test_single_item_records();
        send_sample(16'sh7FFF, 16'sh7FFF, 1'b1);
        send_sample(-16'sh8000, -16'sh8000, 1'b1);
        send_sample(-16'sh8000, 16'sh7FFF, 1'b1);
        send_sample(16'sh0000, 16'sh0000, 1'b1);
        drain();
    endtask

    // Short records across the characteristic phase steps.
    task automatic test_phase_steps();
        set_phase_step(32'h4000_0000);
        send_sample(16'sh7FFF, -16'sh8000, 1'b0);
        send_sample(-16'sh8000, 16'sh7FFF, 1'b0);
        send_sample(16'sh5555, 16'shAAAA, 1'b0);
        send_sample(16'shAAAA, 16'sh5555, 1'b1);
        drain();
        set_phase_step(32'hFFFF_FFFF);
        send_sample(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_sample(16'sh1234, -16'sh1234, 1'b0);
        send_sample(-16'sh8000, 16'sh0001, 1'b1);
        drain();
        set_phase_step(32'h8000_0000);
        send_sample(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_sample(16'sh7FFF, 16'sh7FFF, 1'b1);
        drain();
        set_phase_step(32'h0040_0000);
        send_sample(16'sh7FFF, 16'sh4000, 1'b0);
        send_sample(-16'sh8000, 16'shC000, 1'b0);
        send_sample(16'sh0FF0, 16'shF00F, 1'b0);
        send_sample(16'sh0001, -16'sh0001, 1'b0);
        send_sample(16'sh7FFF, -16'sh8000, 1'b1);
        drain();
    endtask

    // A new step written while a record is open, with the block idle.
    task automatic test_step_change_mid_record();
        set_phase_step(32'h0100_0000);
        send_sample(16'sh6000, 16'sh2000, 1'b0);
        send_sample(-16'sh7000, 16'sh7FFF, 1'b0);
        drain();
        set_phase_step(32'hC000_0000);
        send_sample(16'sh7FFF, -16'sh8000, 1'b0);
        send_sample(-16'sh8000, 16'sh7FFF, 1'b1);
        drain();
    endtask

    // Random records of random length, with occasional step changes.
    task automatic test_random_records(input int n_items, input int in_pct, input int out_pct);
        int sent;
        int len;
        in_idle_pct  = in_pct;
        out_idle_pct = out_pct;
        sent = 0;
        set_phase_step(pick_step());
        while (sent < n_items)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
            for (int k = 0; k < len; k++)
            begin
                send_sample(pick_sample(), pick_sample(), k == len - 1);
                sent++;
                // Now and then retune in the middle of a record.
                if (k != len - 1 && $urandom_range(49) == 0)
                begin
                    drain();
                    set_phase_step(pick_step());
                end
            end
            if ($urandom_range(7) == 0)
            begin
                drain();
                set_phase_step(pick_step());
            end
        end
        drain();
    endtask

    // Test sequence.
    initial
    begin
        in_valid    <= 1'b0;
        e_sample    <= '0;
        h_sample    <= '0;
        last        <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        rst_n       <= 1'b0;
        error_count  = 0;
        in_idle_pct  = 36;
        out_idle_pct = 79;
        step_now     = '0;
        build_quarter_sine();
        clear_bins();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_item_records();
        test_phase_steps();
        test_step_change_mid_record();
        test_random_records(200, 36, 79);
        test_random_records(200, 79, 36);
        test_random_records(200, 0, 0);

        drain();
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/sbpf_pkg.sv
hw/rtl/sbpf_front.sv
hw/rtl/sbpf_queue.sv
hw/rtl/sbpf_back.sv
hw/rtl/single_bin_poynting_flux.sv
sim/tb_single_bin_poynting_flux.sv
